[rtl/pctd_pkg.sv]
// shared types, constants and helper functions of the percent decoder
package pctd_pkg;

    localparam logic [7:0] PERCENT_CHAR = 8'h25;
    localparam logic [7:0] PLUS_CHAR    = 8'h2B;
    localparam logic [7:0] SPACE_CHAR   = 8'h20;
    localparam int         NIB_SHIFT    = 4;
    localparam int         QUEUE_DEPTH  = 4;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    // up to three decoded bytes caused by one request
    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic is_hex(input logic [7:0] c);
        logic r;
        r = ((c >= 8'h30) && (c <= 8'h39)) ||
            ((c >= 8'h61) && (c <= 8'h66)) ||
            ((c >= 8'h41) && (c <= 8'h46));
        return r;
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] r;
        if (c <= 8'h39)
        begin
            r = c[3:0];
        end
        else
        begin
            r = c[3:0] + 4'd9;
        end
        return r;
    endfunction

endpackage

[rtl/pctd_ifs.sv]
// channel interfaces of the percent decoder
interface pctd_raw_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;
    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface pctd_dec_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_end;
    modport source (output valid, output out_byte, output run_last, output stream_end,
                    input ready);
    modport sink (input valid, input out_byte, input run_last, input stream_end,
                  output ready);
endinterface

interface pctd_cfg_if;
    logic valid;
    logic ready;
    logic plus_to_space;
    modport source (output valid, output plus_to_space, input ready);
    modport sink (input valid, input plus_to_space, output ready);
endinterface

[rtl/pctd_front.sv]
// front end: accepts raw bytes, tracks escapes, builds output commands
module pctd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              plus_to_space,
    pctd_raw_if.sink          raw,
    input  pctd_pkg::q_stat_t q_stat,
    output logic              push,
    output pctd_pkg::cmd_t    cmd,
    output pctd_pkg::phase_t  phase
);

    pctd_pkg::phase_t phase_reg;
    pctd_pkg::phase_t phase_next;
    logic [7:0]       held_reg;
    logic [7:0]       held_next;

    logic             accept;
    logic             hex_in;
    logic             f_pct;
    logic             f_emit;
    logic [7:0]       f_byte;
    logic             use_fresh;
    logic [1:0]       pcnt;
    logic [7:0]       p0;
    logic [7:0]       p1;
    logic [7:0]       decoded;
    pctd_pkg::phase_t phase_calc;

    assign raw.ready = !q_stat.full;
    assign accept    = raw.valid && raw.ready;
    assign phase     = phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pctd_pkg::PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

    always_comb
    begin
        hex_in  = pctd_pkg::is_hex(raw.in_byte);
        decoded = {pctd_pkg::hex_val(held_reg), pctd_pkg::hex_val(raw.in_byte)};
        f_pct   = (raw.in_byte == pctd_pkg::PERCENT_CHAR);
        f_emit  = !f_pct || raw.in_last;
        if (f_pct)
        begin
            f_byte = pctd_pkg::PERCENT_CHAR;
        end
        else if (plus_to_space && (raw.in_byte == pctd_pkg::PLUS_CHAR))
        begin
            f_byte = pctd_pkg::SPACE_CHAR;
        end
        else
        begin
            f_byte = raw.in_byte;
        end

        use_fresh  = 1'b0;
        pcnt       = 2'd0;
        p0         = pctd_pkg::PERCENT_CHAR;
        p1         = raw.in_byte;
        phase_calc = pctd_pkg::PH_IDLE;
        held_next  = held_reg;

        case (phase_reg)
            pctd_pkg::PH_PCT:
            begin
                if (hex_in)
                begin
                    if (raw.in_last)
                    begin
                        pcnt = 2'd2;
                    end
                    else
                    begin
                        phase_calc = pctd_pkg::PH_DIGIT;
                        if (accept)
                        begin
                            held_next = raw.in_byte;
                        end
                    end
                end
                else
                begin
                    pcnt      = 2'd1;
                    use_fresh = 1'b1;
                end
            end
            pctd_pkg::PH_DIGIT:
            begin
                if (hex_in)
                begin
                    pcnt = 2'd1;
                    p0   = decoded;
                end
                else
                begin
                    pcnt      = 2'd2;
                    p1        = held_reg;
                    use_fresh = 1'b1;
                end
            end
            default:
            begin
                use_fresh = 1'b1;
            end
        endcase

        // a lone percent with more input to come opens an escape
        if (use_fresh && f_pct && !raw.in_last)
        begin
            phase_calc = pctd_pkg::PH_PCT;
        end
        if (raw.in_last)
        begin
            phase_calc = pctd_pkg::PH_IDLE;
        end
        phase_next = accept ? phase_calc : phase_reg;

        cmd.b0   = p0;
        cmd.b1   = p1;
        cmd.b2   = f_byte;
        cmd.last = raw.in_last;
        cmd.cnt  = pcnt + {1'b0, use_fresh && f_emit};
        case (pcnt)
            2'd0:
            begin
                cmd.b0 = f_byte;
            end
            2'd1:
            begin
                cmd.b1 = f_byte;
            end
            default:
            begin
                cmd.b2 = f_byte;
            end
        endcase
        push = accept && (cmd.cnt != 2'd0);
    end

endmodule

[rtl/pctd_queue.sv]
// command queue between front end and back end
module pctd_queue #(
    parameter int DEPTH = pctd_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pctd_pkg::cmd_t    wdata,
    input  logic              pop,
    output pctd_pkg::cmd_t    rdata,
    output pctd_pkg::q_stat_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pctd_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign q_stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign rdata        = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[rtl/pctd_back.sv]
// back end: walks each command one byte at a time into the output register
module pctd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  pctd_pkg::cmd_t    head,
    input  pctd_pkg::q_stat_t q_stat,
    output logic              pop,
    pctd_dec_if.source        dec
);

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       vld_reg;
    logic       vld_next;
    logic [7:0] byte_reg;
    logic       run_last_reg;
    logic       stream_end_reg;

    logic       fetch;
    logic       fin;
    logic [7:0] sel_byte;

    assign dec.valid      = vld_reg;
    assign dec.out_byte   = byte_reg;
    assign dec.run_last   = run_last_reg;
    assign dec.stream_end = stream_end_reg;

    always_comb
    begin
        fetch = !q_stat.empty && (!vld_reg || dec.ready);
        fin   = (idx_reg == (head.cnt - 2'd1));
        pop   = fetch && fin;
        case (idx_reg)
            2'd0:
            begin
                sel_byte = head.b0;
            end
            2'd1:
            begin
                sel_byte = head.b1;
            end
            default:
            begin
                sel_byte = head.b2;
            end
        endcase
        idx_next = idx_reg;
        if (fetch)
        begin
            idx_next = fin ? 2'd0 : idx_reg + 2'd1;
        end
        if (fetch)
        begin
            vld_next = 1'b1;
        end
        else if (dec.ready)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
            vld_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fetch)
        begin
            byte_reg       <= sel_byte;
            run_last_reg   <= fin;
            stream_end_reg <= fin && head.last;
        end
    end

endmodule

[rtl/percent_decoder.sv]
// top level of the streaming url percent decoder
// raw: one input byte per request, in_last marks the final byte of a string.
// dec: decoded bytes, 0 to 3 per raw request; run_last flags the final byte
//      caused by a request, stream_end the final byte of a string.
// cfg: one-bit register plus_to_space, always ready; write it only while idle.
// path: an accepted request is written into the command queue, and the back end
//      then loads each byte from the queue head into the output register.
// throughput: one raw byte per cycle while each produces at most one output and
//      dec does not stall; the back end drains one output byte per cycle while dec
//      is ready, and the command queue absorbs the extra bytes of a failed escape or a flush.
// raw.ready drops only when the command queue (QUEUE_DEPTH entries) is full.
// reset clears the escape state, the queue and the output valid flag, and sets
// plus_to_space to 0.
// when dec stalls the output byte holds, the queue fills, then raw stalls.
module percent_decoder #(
    parameter int QUEUE_DEPTH = pctd_pkg::QUEUE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    pctd_cfg_if.sink  cfg,
    pctd_raw_if.sink  raw,
    pctd_dec_if.source dec
);

    logic              plus_to_space_reg;
    logic              push;
    logic              pop;
    pctd_pkg::cmd_t    wcmd;
    pctd_pkg::cmd_t    head;
    pctd_pkg::q_stat_t q_stat;
    pctd_pkg::phase_t  phase;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plus_to_space_reg <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            plus_to_space_reg <= cfg.plus_to_space;
        end
    end

    pctd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .plus_to_space (plus_to_space_reg),
        .raw           (raw),
        .q_stat        (q_stat),
        .push          (push),
        .cmd           (wcmd),
        .phase         (phase)
    );

    pctd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  (wcmd),
        .pop    (pop),
        .rdata  (head),
        .q_stat (q_stat)
    );

    pctd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .dec    (dec)
    );

`ifndef SYNTHESIS
    a_end_marks_run: assert property (@(posedge clk) disable iff (!rst_n)
        dec.valid && dec.stream_end |-> dec.run_last)
        else $error("stream_end without run_last");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("push into full queue");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        raw.valid && raw.ready && raw.in_last |=> phase == pctd_pkg::PH_IDLE)
        else $error("escape pending after end of string");

    a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        raw.valid && raw.ready && raw.in_last |-> push)
        else $error("end of string produced no output");
`endif

endmodule

[bench/tb.sv]
// testbench of the percent decoder: random and directed byte strings checked against a predictor
`timescale 1ns / 100ps

module tb;

    class decode_scoreboard;
        typedef struct {
            logic [7:0] data;
            logic       run_last;
            logic       stream_end;
        } dec_byte_t;

        bit               plus_map;
        pctd_pkg::phase_t esc_phase;
        logic [7:0]       first_digit;
        dec_byte_t        burst[$];
        dec_byte_t        decoded[$];

        function new();
            plus_map    = 1'b0;
            esc_phase   = pctd_pkg::PH_IDLE;
            first_digit = 8'd0;
        endfunction

        function void set_plus(input bit v);
            plus_map = v;
        endfunction

        function int pending();
            return decoded.size();
        endfunction

        function bit hex_digit(input logic [7:0] c);
            return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
                   (c >= "A" && c <= "F");
        endfunction

        function logic [3:0] nibble(input logic [7:0] c);
            logic [7:0] t;
            if (c >= "0" && c <= "9")
                t = c - "0";
            else
                t = (c | 8'h20) - "a" + 8'd10;
            return t[3:0];
        endfunction

        function void emit(input logic [7:0] b);
            dec_byte_t r;
            r.data       = b;
            r.run_last   = 1'b0;
            r.stream_end = 1'b0;
            burst.push_back(r);
        endfunction

        // byte seen with no escape pending
        function void plain(input logic [7:0] b, input logic is_last);
            if (b == pctd_pkg::PERCENT_CHAR)
            begin
                if (is_last)
                    emit(pctd_pkg::PERCENT_CHAR);
                else
                    esc_phase = pctd_pkg::PH_PCT;
            end
            else if (plus_map && b == pctd_pkg::PLUS_CHAR)
                emit(pctd_pkg::SPACE_CHAR);
            else
                emit(b);
        endfunction

        function void note_request(input logic [7:0] b, input logic is_last);
            pctd_pkg::phase_t ph;
            ph = esc_phase;
            esc_phase = pctd_pkg::PH_IDLE;
            burst.delete();
            case (ph)
                pctd_pkg::PH_PCT:
                begin
                    if (hex_digit(b))
                    begin
                        if (is_last)
                        begin
                            emit(pctd_pkg::PERCENT_CHAR);
                            emit(b);
                        end
                        else
                        begin
                            first_digit = b;
                            esc_phase = pctd_pkg::PH_DIGIT;
                        end
                    end
                    else
                    begin
                        emit(pctd_pkg::PERCENT_CHAR);
                        plain(b, is_last);
                    end
                end
                pctd_pkg::PH_DIGIT:
                begin
                    if (hex_digit(b))
                        emit({nibble(first_digit), nibble(b)});
                    else
                    begin
                        emit(pctd_pkg::PERCENT_CHAR);
                        emit(first_digit);
                        plain(b, is_last);
                    end
                    first_digit = 8'd0;
                end
                default:
                    plain(b, is_last);
            endcase
            if (is_last)
            begin
                esc_phase = pctd_pkg::PH_IDLE;
                first_digit = 8'd0;
            end
            if (burst.size() > 0)
            begin
                burst[burst.size() - 1].run_last = 1'b1;
                burst[burst.size() - 1].stream_end = is_last;
            end
            foreach (burst[i])
                decoded.push_back(burst[i]);
        endfunction

        function string check_result(input logic [7:0] b, input logic rl, input logic se);
            dec_byte_t e;
            if (decoded.size() == 0)
                return $sformatf("unexpected byte %02h run_last %0b stream_end %0b", b, rl, se);
            e = decoded.pop_front();
            if (b !== e.data || rl !== e.run_last || se !== e.stream_end)
                return $sformatf("got %02h/%0b/%0b, want %02h/%0b/%0b",
                                 b, rl, se, e.data, e.run_last, e.stream_end);
            return "";
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   errors;
    int   idle_pct;
    int   stall_pct;
    int   bytes_sent;
    bit   hold_start;
    int   hold_left;
    int   phase_mode[6] = '{0, 1, 2, 3, 0, 2};
    bit   phase_plus[6] = '{0, 1, 1, 0, 1, 0};

    decode_scoreboard sb;

    pctd_cfg_if cfg_ch();
    pctd_raw_if raw_ch();
    pctd_dec_if dec_ch();

    percent_decoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .raw   (raw_ch),
        .dec   (dec_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // receiver side, with a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_start)
            hold_left <= 150;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        dec_ch.ready <= !hold_start && hold_left == 0 && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && raw_ch.valid && raw_ch.ready)
            sb.note_request(raw_ch.in_byte, raw_ch.in_last);
    end

    always @(posedge clk)
    begin : dec_monitor
        string msg;
        if (rst_n && dec_ch.valid && dec_ch.ready)
        begin
            msg = sb.check_result(dec_ch.out_byte, dec_ch.run_last, dec_ch.stream_end);
            if (msg != "")
                report(msg);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(99) < idle_pct)
        begin
            raw_ch.valid <= 1'b0;
            @(posedge clk);
        end
        raw_ch.valid   <= 1'b1;
        raw_ch.in_byte <= b;
        raw_ch.in_last <= is_last;
        @(posedge clk);
        while (!raw_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input bit end_flag);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], end_flag && i == s.len() - 1);
    endtask

    task automatic write_plus_to_space(input logic v);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.plus_to_space <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        sb.set_plus(v);
    endtask

    task automatic settle();
        raw_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_hex();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(21)];
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (sb.hex_digit(c));
        return c;
    endfunction

    task automatic send_random_string();
        logic [7:0] text[$];
        int         tokens;
        int         kind;
        tokens = $urandom_range(8, 1);
        for (int t = 0; t < tokens; t++)
        begin
            kind = $urandom_range(99);
            if (kind < 40)
            begin
                text.push_back(pctd_pkg::PERCENT_CHAR);
                text.push_back(rand_hex());
                text.push_back(rand_hex());
            end
            else if (kind < 60)
                text.push_back(8'($urandom_range(8'h7e, 8'h20)));
            else if (kind < 70)
                text.push_back(pctd_pkg::PLUS_CHAR);
            else if (kind < 78)
            begin
                // escape broken at its second character
                text.push_back(pctd_pkg::PERCENT_CHAR);
                text.push_back(rand_non_hex());
            end
            else if (kind < 85)
            begin
                // escape broken at its third character
                text.push_back(pctd_pkg::PERCENT_CHAR);
                text.push_back(rand_hex());
                text.push_back(rand_non_hex());
            end
            else
                text.push_back(8'($urandom_range(255)));
        end
        // string ending inside an escape
        if ($urandom_range(9) == 0)
        begin
            text.push_back(pctd_pkg::PERCENT_CHAR);
            if ($urandom_range(1))
                text.push_back(rand_hex());
        end
        foreach (text[i])
            send_byte(text[i], i == text.size() - 1);
    endtask

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        sb = new();
        errors = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_start = 1'b0;
        hold_left = 0;
        rst_n = 1'b0;
        raw_ch.valid = 1'b0;
        raw_ch.in_byte = 8'd0;
        raw_ch.in_last = 1'b0;
        dec_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.plus_to_space = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_plus_to_space(1'b1);
        send_text("%41", 1'b0);
        send_text("%6a", 1'b0);
        send_text("+", 1'b0);
        send_text("%2B", 1'b0);
        send_text("%4g", 1'b0);
        send_text("%z", 1'b0);
        send_text("%4%41", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_text("%F", 1'b1);
        send_text("%", 1'b1);

        for (int p = 0; p < 6; p++)
        begin
            settle();
            write_plus_to_space(phase_plus[p]);
            case (phase_mode[p])
                1:
                begin
                    idle_pct = 81;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 81;
                end
                3:
                begin
                    idle_pct = 27;
                    stall_pct = 27;
                end
                default:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
            endcase
            if (p == 4)
            begin
                hold_start <= 1'b1;
                @(posedge clk);
                hold_start <= 1'b0;
            end
            bytes_sent = 0;
            while (bytes_sent < 64)
                send_random_string();
        end

        settle();
        repeat (12) @(posedge clk);
        if (sb.pending() != 0)
            report($sformatf("%0d decoded bytes never arrived", sb.pending()));
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
